/* rtl/core/tsma_pkg.sv */
// Package: shared constants, register indexes and sequencer state type.
`timescale 1ns / 1ps
package tsma_pkg;

    localparam int SLOT_W = 16;
    localparam int Q_W    = 8;
    localparam int DEG_W  = 3;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_DEGREE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_COEFFS  = 2'd2;

    localparam logic [Q_W-1:0] Q_MIN = 8'd2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_XMOD = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_RED  = 6'b010000,
        ST_DONE = 6'b100000
    } seq_state_t;

endpackage

/* rtl/core/tsma_slot_schedule_bit.sv */
// Top level: polynomial slot schedule decision with a shared bit-serial modulo unit.
`timescale 1ns / 1ps
// Takes one slot number and reports whether the node owns that slot: the slot is split
// into subframe index (slot div q) and position (slot mod q), the coefficient polynomial
// is evaluated at the subframe index modulo q by Horner's rule, and transmit is raised
// when the position equals that residue. One restoring divider, one remainder bit per
// cycle over a 17-bit dividend, does all the work: first the slot division, then the
// reduction of the subframe index, then for each coefficient one multiply-add step
// followed by its reduction. A new slot word is taken the cycle after the result word
// leaves. Configuration writes are always taken, since cfg_ready is tied high.
module tsma_slot_schedule_bit #(
    parameter int MAX_DEGREE = 7,
    parameter int COEFF_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsma_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tsma_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tsma_pkg::SLOT_W-1:0]   slot_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          transmit,
    output logic [tsma_pkg::Q_W-1:0]      poly_residue
);
    import tsma_pkg::*;

    localparam int SUM_W   = ((COEFF_BITS > 2 * Q_W) ? COEFF_BITS : 2 * Q_W) + 1;
    localparam int DIV_W   = (SUM_W > SLOT_W) ? SUM_W : SLOT_W;
    localparam int CNT_W   = $clog2(DIV_W + 1);
    localparam int K_W     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
    localparam int SHAMT_W = $clog2(COEFF_BITS * MAX_DEGREE + 1);

    logic [Q_W-1:0]   modulus_reg;
    logic [DEG_W-1:0] degree_reg;
    logic [CFG_W-1:0] coeffs_reg;

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [Q_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [Q_W-1:0]   pos_reg, pos_next;
    logic [Q_W-1:0]   x_reg, x_next;
    logic [Q_W-1:0]   r_reg, r_next;
    logic [K_W-1:0]   k_reg, k_next;

    logic [Q_W-1:0]        q_eff;
    logic [K_W-1:0]        deg_eff;
    logic [Q_W:0]          trial;
    logic [Q_W:0]          diff;
    logic                  ge;
    logic [Q_W-1:0]        rem_step;
    logic [DIV_W-1:0]      div_step;
    logic [SHAMT_W-1:0]    shamt;
    logic [CFG_W-1:0]      coeff_shifted;
    logic [COEFF_BITS-1:0] coeff;
    logic [2*Q_W-1:0]      prod;
    logic [DIV_W-1:0]      mac;

    assign q_eff   = (modulus_reg < Q_MIN) ? Q_MIN : modulus_reg;
    assign deg_eff = (int'(degree_reg) > MAX_DEGREE) ? K_W'(MAX_DEGREE) : K_W'(degree_reg);

    // restoring divider step, remainder stays below q
    assign trial    = {rem_reg, div_reg[DIV_W-1]};
    assign ge       = (trial >= {1'b0, q_eff});
    assign diff     = trial - {1'b0, q_eff};
    assign rem_step = ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
    assign div_step = {div_reg[DIV_W-2:0], ge};

    // Horner multiply-add; coefficients past bit 63 shift in as zero
    assign shamt         = SHAMT_W'(COEFF_BITS * int'(k_reg));
    assign coeff_shifted = coeffs_reg >> shamt;
    assign coeff         = coeff_shifted[COEFF_BITS-1:0];
    assign prod          = r_reg * x_reg;
    assign mac           = DIV_W'(prod) + DIV_W'(coeff);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        pos_next   = pos_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_next   = DIV_W'(slot_number);
                    rem_next   = '0;
                    cnt_next   = CNT_W'(DIV_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                div_next = div_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    pos_next   = rem_step;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(DIV_W);
                    state_next = ST_XMOD;
                end
            end
            ST_XMOD:
            begin
                rem_next = rem_step;
                div_next = div_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    x_next     = rem_step;
                    r_next     = '0;
                    k_next     = deg_eff;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_next   = mac;
                rem_next   = '0;
                cnt_next   = CNT_W'(DIV_W);
                state_next = ST_RED;
            end
            ST_RED:
            begin
                rem_next = rem_step;
                div_next = div_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    r_next = rem_step;
                    if (k_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        pos_reg <= pos_next;
        x_reg   <= x_next;
        r_reg   <= r_next;
        k_reg   <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= Q_MIN;
            degree_reg  <= '0;
            coeffs_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODULUS: modulus_reg <= cfg_data[Q_W-1:0];
                REG_DEGREE:  degree_reg  <= cfg_data[DEG_W-1:0];
                REG_COEFFS:  coeffs_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_DONE);
    assign transmit     = (pos_reg == r_reg);
    assign poly_residue = r_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (poly_residue < q_eff))
        else $error("residue not below modulus");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_XMOD || state_reg == ST_RED)
        |-> (rem_reg < q_eff))
        else $error("divider remainder out of range");

    a_done_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_RED && $past(k_reg) == '0))
        else $error("result raised before last coefficient");

endmodule

/* bench/tsma_slot_schedule_bit_tb.sv */
// Testbench for the polynomial slot schedule block: directed and random slots against a local predictor.
`timescale 1ns / 1ps
module tsma_slot_schedule_bit_tb;
    import tsma_pkg::*;

    localparam int COEFF_BITS = 8;
    localparam int MAX_DEGREE = 7;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic           transmit;
        logic [Q_W-1:0] residue;
    } decision_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index    = REG_MODULUS;
    logic [CFG_W-1:0]  cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [SLOT_W-1:0] slot_number  = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic              transmit;
    logic [Q_W-1:0]    poly_residue;

    // local copy of the configuration registers
    logic [Q_W-1:0]    cur_modulus = Q_MIN;
    logic [DEG_W-1:0]  cur_degree  = '0;
    logic [CFG_W-1:0]  cur_coeffs  = '0;

    decision_t         owed_decisions[$];
    int unsigned       mismatches = 0;
    int unsigned       gap_max    = 0;
    int unsigned       stall_max  = 0;

    tsma_slot_schedule_bit #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEFF_BITS (COEFF_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .slot_number  (slot_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .transmit     (transmit),
        .poly_residue (poly_residue)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic decision_t schedule_decision(input logic [SLOT_W-1:0] slot);
        int unsigned q;
        int unsigned deg;
        int unsigned x;
        int unsigned acc;
        decision_t   d;
        q   = (cur_modulus < Q_MIN) ? Q_MIN : cur_modulus;
        deg = (cur_degree > MAX_DEGREE) ? MAX_DEGREE : cur_degree;
        x   = (slot / q) % q;
        acc = 0;
        for (int i = int'(deg); i >= 0; i--)
            acc = (acc * x + cur_coeffs[COEFF_BITS*i +: COEFF_BITS] % q) % q;
        d.transmit = ((slot % q) == acc);
        d.residue  = acc[Q_W-1:0];
        return d;
    endfunction

    task automatic send_slot(input logic [SLOT_W-1:0] slot);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        slot_number <= slot;
        do
            @(posedge clk);
        while (!in_ready);
        owed_decisions.push_back(schedule_decision(slot));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (owed_decisions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MODULUS: cur_modulus = data[Q_W-1:0];
            REG_DEGREE:  cur_degree  = data[DEG_W-1:0];
            REG_COEFFS:  cur_coeffs  = data;
            default:     ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [Q_W-1:0] q, input logic [DEG_W-1:0] k,
                              input logic [CFG_W-1:0] coeffs);
        wait_idle();
        write_reg(REG_MODULUS, {{(CFG_W-Q_W){1'b1}}, q});
        write_reg(REG_DEGREE, {{(CFG_W-DEG_W){1'b1}}, k});
        write_reg(REG_COEFFS, coeffs);
    endtask

    task automatic test_reset_state();
        gap_max   = 16;
        stall_max = 16;
        send_slot(16'd0);
        send_slot(16'd1);
        send_slot(16'd2);
        send_slot(16'd3);
        send_slot(16'hFFFF);
    endtask

    task automatic test_small_modulus();
        set_config(8'd0, 3'd1, 64'h0000_0000_0000_0301);
        send_slot(16'd0);
        send_slot(16'd3);
        wait_idle();
        write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_slot(16'd2);
        set_config(8'd1, 3'd2, 64'h0000_0000_0001_0100);
        send_slot(16'd1);
    endtask

    task automatic test_wide_coefficients();
        set_config(8'd255, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_slot(16'd0);
        send_slot(16'hFFFF);
        set_config(8'd255, 3'd7, 64'hFEDC_BA98_7654_3210);
        send_slot(16'd0);
        send_slot(16'd255 * 16'd254 + 16'd7);
        send_slot(16'hAAAA);
    endtask

    task automatic test_slot_beyond_frame();
        set_config(8'd3, 3'd2, 64'h0000_0000_0005_0402);
        send_slot(16'd9);
        send_slot(16'd40000);
        send_slot(16'h5555);
    endtask

    task automatic test_transmit_hits();
        decision_t d;
        set_config(8'd7, 3'd3, 64'h0000_0000_0306_0204);
        for (int x = 0; x < 4; x++)
        begin
            d = schedule_decision(SLOT_W'(7 * x));
            send_slot(SLOT_W'(7 * x + d.residue));
        end
    endtask

    task automatic test_random();
        logic [Q_W-1:0]    q;
        int unsigned       qq;
        int unsigned       x;
        int unsigned       pick;
        logic [SLOT_W-1:0] base;
        logic [SLOT_W-1:0] slot;
        decision_t         d;
        for (int phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       q = Q_MIN;
                1:       q = 8'd255;
                2:       q = Q_W'($urandom_range(0, 13));
                default: q = Q_W'($urandom_range(0, 255));
            endcase
            set_config(q, DEG_W'($urandom_range(0, 7)), {$urandom(), $urandom()});
            gap_max   = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 3 : 16;
            stall_max = (phase % 4 == 0) ? 0 : 16;
            qq = (q < Q_MIN) ? Q_MIN : q;
            for (int n = 0; n < 130; n++)
            begin
                pick = $urandom_range(0, 9);
                x    = $urandom_range(0, qq - 1);
                base = SLOT_W'(x * qq);
                if (pick < 5)
                begin
                    d    = schedule_decision(base);
                    slot = base + SLOT_W'(d.residue);
                end
                else if (pick < 8)
                    slot = SLOT_W'($urandom_range(0, qq * qq - 1));
                else
                    slot = SLOT_W'($urandom_range(0, 16'hFFFF));
                send_slot(slot);
            end
        end
    endtask

    initial
    begin : result_ready
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                hold = $urandom_range(0, stall_max);
                if (hold != 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (hold == 0)
                    out_ready <= 1'b1;
                else
                    hold--;
            end
        end
    end

    always @(posedge clk)
    begin : check_decision
        decision_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_decisions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: transmit %0d residue %0d",
                             transmit, poly_residue);
            end
            else
            begin
                want = owed_decisions.pop_front();
                if (transmit !== want.transmit || poly_residue !== want.residue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: transmit exp %0d got %0d, residue exp %0d got %0d",
                                 want.transmit, transmit, want.residue, poly_residue);
                end
            end
        end
    end

    initial
    begin
        #9_600_000;
        $display("tsma_slot_schedule_bit_tb: FAIL");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_state();
        test_small_modulus();
        test_wide_coefficients();
        test_slot_beyond_frame();
        test_transmit_hits();
        test_random();
        wait_idle();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && owed_decisions.size() == 0)
            $display("tsma_slot_schedule_bit_tb: PASS");
        else
            $display("tsma_slot_schedule_bit_tb: FAIL");
        $finish;
    end

endmodule
